// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scrambler RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define GSBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gsbs assertion failed");
// Boolean condition must never be seen outside reset.
`define GSBS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gsbs forbidden condition seen");
`else
`define GSBS_ASSERT(lbl, clk, rst_n, prop)
`define GSBS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/gsbs_pkg.sv =====
// Package for the Gold sequence scrambler: widths, register indexes, types and LFSR helpers.
`timescale 1ns / 1ps
`default_nettype none
package gsbs_pkg;

  // Default parameter values.
  localparam int unsigned LanesDefault     = 8;
  localparam int unsigned SkipCountDefault = 1600;
  localparam int unsigned PosBitsDefault   = 16;

  // Fixed field widths.
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned CountWidth  = 4;
  localparam int unsigned LfsrWidth   = 31;
  localparam int unsigned SeqLenWidth = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = LfsrWidth;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgInitSeed  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgSeqLength = 1'b1;

  typedef logic [LfsrWidth-1:0] lfsr_t;
  typedef lfsr_t [LfsrWidth-1:0] jump_mat_t;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic scr;   // scrambled bit, zero when the lane is not used
    logic used;  // lane consumed a sequence bit
    logic miss;  // lane held a valid bit but no sequence bit was left
  } lane_res_t;

  // One step of the first register: x1(n+31) = x1(n+3) ^ x1(n).
  function automatic lfsr_t adv_x1(lfsr_t r);
    return {r[0] ^ r[3], r[LfsrWidth-1:1]};
  endfunction

  // One step of the second register: x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n).
  function automatic lfsr_t adv_x2(lfsr_t r);
    return {r[0] ^ r[1] ^ r[2] ^ r[3], r[LfsrWidth-1:1]};
  endfunction

  // First register after the initial skip; evaluated at elaboration.
  function automatic lfsr_t x1_start(int unsigned skip);
    lfsr_t r;
    r = lfsr_t'(1);
    for (int unsigned k = 0; k < skip; k++) begin
      r = adv_x1(r);
    end
    return r;
  endfunction

  // Column j is the skipped image of seed bit j alone; evaluated at elaboration.
  function automatic jump_mat_t x2_jump_matrix(int unsigned skip);
    jump_mat_t m;
    for (int unsigned j = 0; j < LfsrWidth; j++) begin
      m[j] = lfsr_t'(1) << j;
    end
    for (int unsigned k = 0; k < skip; k++) begin
      for (int unsigned j = 0; j < LfsrWidth; j++) begin
        m[j] = adv_x2(m[j]);
      end
    end
    return m;
  endfunction

  // GF(2) product of the jump matrix and a seed.
  function automatic lfsr_t apply_jump(jump_mat_t m, lfsr_t seed);
    lfsr_t acc;
    acc = '0;
    for (int unsigned j = 0; j < LfsrWidth; j++) begin
      if (seed[j]) begin
        acc = acc ^ m[j];
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gsbs_lane.sv =====
// One scrambler lane: gates and scrambles a single data bit of the beat.
`timescale 1ns / 1ps
`default_nettype none
module gsbs_lane
  import gsbs_pkg::*;
#(
  parameter int unsigned LANE_IDX = 0,
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  wire logic                  data_bit_i,
  input  wire logic                  seq_bit_i,
  input  wire logic [CountWidth-1:0] bit_count_i,
  input  wire logic [POS_BITS-1:0]   pos_i,
  input  wire logic [POS_BITS-1:0]   limit_i,
  output lane_res_t                  res_o
);

  logic            valid;
  logic            avail;
  logic [POS_BITS:0] lane_pos;

  // The lane holds a data bit when its index is below the bit count.
  assign valid = bit_count_i > CountWidth'(LANE_IDX);

  // Sequence position of this lane, compared against the usable length.
  assign lane_pos = {1'b0, pos_i} + (POS_BITS + 1)'(LANE_IDX);
  assign avail    = lane_pos < {1'b0, limit_i};

  always_comb begin
    res_o.used = valid & avail;
    res_o.miss = valid & ~avail;
    res_o.scr  = res_o.used & (data_bit_i ^ seq_bit_i);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gsbs_merge.sv =====
// Merge stage: packs lane results into the output byte, flag and step count.
`timescale 1ns / 1ps
`default_nettype none
module gsbs_merge
  import gsbs_pkg::*;
#(
  parameter int unsigned N_LANES = LanesDefault,
  localparam int unsigned StepWidth = $clog2(N_LANES + 1)
) (
  input  wire lane_res_t [N_LANES-1:0] lane_res_i,
  output logic [DataWidth-1:0]         scrambled_o,
  output logic                         exhausted_o,
  output logic [StepWidth-1:0]         step_o
);

  // Collect scrambled bits, the miss flag and the count of used lanes.
  always_comb begin
    scrambled_o = '0;
    exhausted_o = 1'b0;
    step_o      = '0;
    for (int unsigned i = 0; i < N_LANES; i++) begin
      scrambled_o[i] = lane_res_i[i].scr;
      exhausted_o    = exhausted_o | lane_res_i[i].miss;
      step_o         = step_o + StepWidth'(lane_res_i[i].used);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gsbs_advance.sv =====
// Multi-step LFSR advance: moves both registers forward by the beat's step count.
`timescale 1ns / 1ps
`default_nettype none
module gsbs_advance
  import gsbs_pkg::*;
#(
  parameter int unsigned N_LANES = LanesDefault,
  localparam int unsigned StepWidth = $clog2(N_LANES + 1),
  localparam int unsigned ExtWidth  = LfsrWidth + N_LANES
) (
  input  wire lfsr_t                x1_i,
  input  wire lfsr_t                x2_i,
  input  wire logic [StepWidth-1:0] step_i,
  output lfsr_t                     x1_o,
  output lfsr_t                     x2_o
);

  logic [ExtWidth-1:0] ext1;
  logic [ExtWidth-1:0] ext2;

  // Extend both sequences by N_LANES elements; each new element uses earlier elements only.
  always_comb begin
    ext1 = '0;
    ext2 = '0;
    ext1[LfsrWidth-1:0] = x1_i;
    ext2[LfsrWidth-1:0] = x2_i;
    for (int unsigned j = 0; j < N_LANES; j++) begin
      ext1[LfsrWidth+j] = ext1[j] ^ ext1[j+3];
      ext2[LfsrWidth+j] = ext2[j] ^ ext2[j+1] ^ ext2[j+2] ^ ext2[j+3];
    end
  end

  // Window the extended sequences at the step count.
  assign x1_o = ext1[step_i +: LfsrWidth];
  assign x2_o = ext2[step_i +: LfsrWidth];

endmodule
`default_nettype wire

// ===== hw/rtl/gold_sequence_bit_scrambler_core.sv =====
// Gold sequence bit scrambler: top level with state, lanes, merge stage and output register.
//
// Input channel (in_valid_i / in_stall_o) carries one beat: restart_i, up to eight data bits
// in data_bits_i (earliest bit in bit 0) and bit_count_i. Output channel
// (out_valid_o / out_stall_i) returns scrambled_bits_o and exhausted_o for every beat.
// The block accepts one beat per cycle when not stalled. A result appears in the cycle after
// its beat is accepted; the LFSR state update is a combinational loop through the lanes,
// the merge stage and a windowed multi-step advance, which sets the one-beat-per-cycle rate.
// The output register lets a new beat enter in the same cycle that the held result is
// taken; when the receiver stalls with a result held, in_stall_o rises and the input waits.
// Configuration is a write port (cfg_we_i, cfg_index_i, cfg_wdata_i). A seed write stores
// the seed already jumped past the skipped prefix, so a restart loads it directly.
// Writes only take effect at the next restart (seed) or the next beat (length).
// Reset clears the output valid flag, the seed and the length, loads the first register
// with its post-skip state and clears the second register and the bit position.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gold_sequence_bit_scrambler_core
  import gsbs_pkg::*;
#(
  parameter int unsigned LANES         = LanesDefault,
  parameter int unsigned SKIP_COUNT    = SkipCountDefault,
  parameter int unsigned POSITION_BITS = PosBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input channel.
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    restart_i,
  input  wire logic [DataWidth-1:0]    data_bits_i,
  input  wire logic [CountWidth-1:0]   bit_count_i,
  // Output channel.
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [DataWidth-1:0]         scrambled_bits_o,
  output logic                         exhausted_o,
  // Configuration write port.
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i
);

  localparam int unsigned NLanes    = (LANES < DataWidth) ? LANES : DataWidth;
  localparam int unsigned StepWidth = $clog2(NLanes + 1);
  localparam int unsigned LimWidth  = (POSITION_BITS > SeqLenWidth) ? POSITION_BITS
                                                                    : SeqLenWidth;
  localparam lfsr_t     X1Start = x1_start(SKIP_COUNT);
  localparam jump_mat_t X2Jump  = x2_jump_matrix(SKIP_COUNT);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  lfsr_t                      x1_q, x1_d;
  lfsr_t                      x2_q, x2_d;
  lfsr_t                      seed_jump_q;
  logic [SeqLenWidth-1:0]     seq_len_q;
  logic [POSITION_BITS-1:0]   pos_q, pos_d;
  logic                       out_valid_q;
  logic [DataWidth-1:0]       scr_q;
  logic                       exh_q;

  logic                       in_fire;
  lfsr_t                      cur_x1;
  lfsr_t                      cur_x2;
  logic [POSITION_BITS-1:0]   cur_pos;
  logic [LimWidth-1:0]        lim_wide;
  logic [POSITION_BITS-1:0]   limit;
  lane_res_t [NLanes-1:0]     lane_res;
  logic [DataWidth-1:0]       merge_scr;
  logic                       merge_exh;
  logic [StepWidth-1:0]       step_cnt;

  // Handshake: stall only while a held result is itself stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Configuration registers; the seed is stored already jumped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_jump_q <= '0;
      seq_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgInitSeed:  seed_jump_q <= apply_jump(X2Jump, cfg_wdata_i);
        CfgSeqLength: seq_len_q   <= cfg_wdata_i[SeqLenWidth-1:0];
        default: ;
      endcase
    end
  end

  // Working state for this beat, with restart applied first.
  assign cur_x1  = restart_i ? X1Start : x1_q;
  assign cur_x2  = restart_i ? seed_jump_q : x2_q;
  assign cur_pos = restart_i ? '0 : pos_q;

  // Usable length: the programmed length, capped so the position never wraps.
  assign lim_wide = (LimWidth'(seq_len_q) < LimWidth'(PosMax)) ? LimWidth'(seq_len_q)
                                                              : LimWidth'(PosMax);
  assign limit    = lim_wide[POSITION_BITS-1:0];

  // Parallel lanes, one per data bit.
  for (genvar i = 0; i < NLanes; i++) begin : g_lane
    gsbs_lane #(
      .LANE_IDX (i),
      .POS_BITS (POSITION_BITS)
    ) u_lane (
      .data_bit_i  (data_bits_i[i]),
      .seq_bit_i   (cur_x1[i] ^ cur_x2[i]),
      .bit_count_i (bit_count_i),
      .pos_i       (cur_pos),
      .limit_i     (limit),
      .res_o       (lane_res[i])
    );
  end

  // Merge lane results.
  gsbs_merge #(
    .N_LANES (NLanes)
  ) u_merge (
    .lane_res_i  (lane_res),
    .scrambled_o (merge_scr),
    .exhausted_o (merge_exh),
    .step_o      (step_cnt)
  );

  // Advance both LFSRs by the number of used lanes.
  gsbs_advance #(
    .N_LANES (NLanes)
  ) u_advance (
    .x1_i   (cur_x1),
    .x2_i   (cur_x2),
    .step_i (step_cnt),
    .x1_o   (x1_d),
    .x2_o   (x2_d)
  );

  assign pos_d = cur_pos + POSITION_BITS'(step_cnt);

  // Sequence state update on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q  <= X1Start;
      x2_q  <= '0;
      pos_q <= '0;
    end else if (in_fire) begin
      x1_q  <= x1_d;
      x2_q  <= x2_d;
      pos_q <= pos_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scr_q <= merge_scr;
      exh_q <= merge_exh;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scrambled_bits_o = scr_q;
  assign exhausted_o      = exh_q;

  // Checks on the block's own logic.
  `GSBS_ASSERT_NEVER(a_stall_without_result, clk_i, rst_ni, !out_valid_q && in_stall_o)
  `GSBS_ASSERT(a_step_within_count, clk_i, rst_ni, in_fire |-> (step_cnt <= bit_count_i))
  `GSBS_ASSERT(a_pos_monotonic, clk_i, rst_ni, in_fire && !restart_i |=> pos_q >= $past(pos_q))
  `GSBS_ASSERT(a_exhaust_at_limit, clk_i, rst_ni, in_fire && merge_exh |=> pos_q >= $past(limit))

endmodule
`default_nettype wire
